/* design/rwl_pkg.sv */
// shared types and constants for the reader-writer lock manager
`timescale 1ns / 1ps

package rwl_pkg;

  localparam int REQ_TYPE_W   = 2;
  localparam int FIELD_ID_W   = 8;
  localparam int STATUS_W     = 2;
  localparam int READER_CNT_W = 9;
  localparam int MAX_RESULTS  = 16;
  localparam logic [READER_CNT_W-1:0] READER_MAX = 9'd511;

  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_RD_ACQ = 2'd0,
    REQ_RD_REL = 2'd1,
    REQ_WR_ACQ = 2'd2,
    REQ_WR_REL = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANT = 2'd0,
    ST_FULL  = 2'd1,
    ST_STRAY = 2'd2
  } status_t;

  typedef struct packed {
    req_kind_t               kind;
    logic [FIELD_ID_W-1:0]   id;
  } cmd_t;

endpackage

/* design/rwl_if.sv */
// request and grant channel interfaces
`timescale 1ns / 1ps

interface rwl_req_if import rwl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [FIELD_ID_W-1:0] requester_id;

  modport source(output valid, req_type, requester_id, input ready);
  modport sink(input valid, req_type, requester_id, output ready);
endinterface

interface rwl_grant_if import rwl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_ID_W-1:0] grant_id;
  logic                  grant_is_write;
  logic [STATUS_W-1:0]   status;
  logic                  last;

  modport source(output valid, grant_id, grant_is_write, status, last, input ready);
  modport sink(input valid, grant_id, grant_is_write, status, last, output ready);
endinterface

/* design/rwl_ram.sv */
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module rwl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/rwl_front.sv */
// request intake: classifies requests and buffers them in a two-entry queue
`timescale 1ns / 1ps

module rwl_front import rwl_pkg::*; #(
  parameter int ID_BITS = 8
) (
  input  logic          clk,
  input  logic          rst,
  rwl_req_if.sink       req,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output cmd_t          cmd
);

  localparam logic [FIELD_ID_W-1:0] ID_MASK =
    FIELD_ID_W'((17'd1 << ID_BITS) - 17'd1);

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       in_cmd;

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_comb begin
    in_cmd.kind = req_kind_t'(req.req_type);
    in_cmd.id   = req.requester_id & ID_MASK;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

/* design/rwl_back.sv */
// lock engine: holder state, fifo wait queues and result register
`timescale 1ns / 1ps

module rwl_back import rwl_pkg::*; #(
  parameter int WAIT_DEPTH = 16,
  parameter int ID_BITS    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  cmd_t          cmd,
  rwl_grant_if.source   grant
);

  localparam int ID_W   = (ID_BITS < FIELD_ID_W) ? ID_BITS : FIELD_ID_W;
  localparam int PTR_W  = $clog2(WAIT_DEPTH);
  localparam int CNT_W  = $clog2(WAIT_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int NRES_W = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_POP  = 2'b10
  } state_t;

  state_t                  state, state_next;
  logic                    pop_rd, pop_rd_next;
  logic [NRES_W-1:0]       nres, nres_next;
  logic [READER_CNT_W-1:0] active, active_next;
  logic                    wholds, wholds_next;
  logic [PTR_W-1:0]        rhead, rhead_next;
  logic [CNT_W-1:0]        rcnt, rcnt_next;
  logic [PTR_W-1:0]        whead, whead_next;
  logic [CNT_W-1:0]        wcnt, wcnt_next;

  logic                  out_valid;
  logic [FIELD_ID_W-1:0] out_id;
  logic                  out_wr;
  status_t               out_st;
  logic                  out_last;
  logic                  out_free;

  logic                  em;
  logic [FIELD_ID_W-1:0] em_id;
  logic                  em_wr;
  status_t               em_st;
  logic                  em_last;
  logic                  more;

  logic [SUM_W-1:0] r_sum, w_sum;
  logic [PTR_W-1:0] r_slot, w_slot;
  logic [PTR_W-1:0] rhead_inc, whead_inc;
  logic             r_we, w_we;
  logic [ID_W-1:0]  r_rdata, w_rdata;

  assign out_free = !out_valid || grant.ready;

  // tail slot of each queue, head plus count wraps at most once
  always_comb begin
    r_sum  = SUM_W'(rhead) + SUM_W'(rcnt);
    w_sum  = SUM_W'(whead) + SUM_W'(wcnt);
    r_slot = (r_sum >= SUM_W'(WAIT_DEPTH)) ? PTR_W'(r_sum - SUM_W'(WAIT_DEPTH))
                                           : PTR_W'(r_sum);
    w_slot = (w_sum >= SUM_W'(WAIT_DEPTH)) ? PTR_W'(w_sum - SUM_W'(WAIT_DEPTH))
                                           : PTR_W'(w_sum);
    rhead_inc = (rhead == PTR_W'(WAIT_DEPTH - 1)) ? '0 : rhead + 1'b1;
    whead_inc = (whead == PTR_W'(WAIT_DEPTH - 1)) ? '0 : whead + 1'b1;
  end

  always_comb begin
    state_next  = state;
    pop_rd_next = pop_rd;
    nres_next   = nres;
    active_next = active;
    wholds_next = wholds;
    rhead_next  = rhead;
    rcnt_next   = rcnt;
    whead_next  = whead;
    wcnt_next   = wcnt;
    cmd_ready   = 1'b0;
    r_we        = 1'b0;
    w_we        = 1'b0;
    em          = 1'b0;
    em_id       = cmd.id;
    em_wr       = 1'b0;
    em_st       = ST_GRANT;
    em_last     = 1'b1;
    more        = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd.kind)
            REQ_RD_ACQ: begin
              if (wholds || wcnt != '0) begin
                if (rcnt != CNT_W'(WAIT_DEPTH)) begin
                  r_we      = 1'b1;
                  rcnt_next = rcnt + 1'b1;
                end else begin
                  em    = 1'b1;
                  em_st = ST_FULL;
                end
              end else if (active == READER_MAX) begin
                em    = 1'b1;
                em_st = ST_FULL;
              end else begin
                active_next = active + 1'b1;
                em          = 1'b1;
              end
            end
            REQ_RD_REL: begin
              if (active == '0) begin
                em    = 1'b1;
                em_st = ST_STRAY;
              end else begin
                active_next = active - 1'b1;
                // last reader out hands the lock to the oldest writer
                if (active == READER_CNT_W'(1) && wcnt != '0) begin
                  pop_rd_next = 1'b0;
                  state_next  = ST_POP;
                end
              end
            end
            REQ_WR_ACQ: begin
              em_wr = 1'b1;
              if (active != '0 || wholds || wcnt != '0) begin
                if (wcnt != CNT_W'(WAIT_DEPTH)) begin
                  w_we      = 1'b1;
                  wcnt_next = wcnt + 1'b1;
                end else begin
                  em    = 1'b1;
                  em_st = ST_FULL;
                end
              end else begin
                wholds_next = 1'b1;
                em          = 1'b1;
              end
            end
            REQ_WR_REL: begin
              em_wr = 1'b1;
              if (!wholds) begin
                em    = 1'b1;
                em_st = ST_STRAY;
              end else begin
                wholds_next = 1'b0;
                if (rcnt != '0) begin
                  pop_rd_next = 1'b1;
                  nres_next   = '0;
                  state_next  = ST_POP;
                end else if (wcnt != '0) begin
                  pop_rd_next = 1'b0;
                  state_next  = ST_POP;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        if (out_free) begin
          em = 1'b1;
          if (pop_rd) begin
            rhead_next  = rhead_inc;
            rcnt_next   = rcnt - 1'b1;
            active_next = active + 1'b1;
            nres_next   = nres + 1'b1;
            // keep draining readers while any wait, the burst has room and the reader count is below max
            more = (rcnt > CNT_W'(1)) && (nres_next < NRES_W'(MAX_RESULTS)) &&
                   (active_next < READER_MAX);
            em_id   = FIELD_ID_W'(r_rdata);
            em_last = !more;
            if (!more) begin
              state_next = ST_IDLE;
            end
          end else begin
            whead_next  = whead_inc;
            wcnt_next   = wcnt - 1'b1;
            wholds_next = 1'b1;
            em_id       = FIELD_ID_W'(w_rdata);
            em_wr       = 1'b1;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // read address follows the next head so the registered read data lines up with the head
  rwl_ram #(.WIDTH(ID_W), .DEPTH(WAIT_DEPTH)) u_reader_q (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_slot),
    .wdata (cmd.id[ID_W-1:0]),
    .raddr (rhead_next),
    .rdata (r_rdata)
  );

  rwl_ram #(.WIDTH(ID_W), .DEPTH(WAIT_DEPTH)) u_writer_q (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_slot),
    .wdata (cmd.id[ID_W-1:0]),
    .raddr (whead_next),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pop_rd    <= 1'b0;
      nres      <= '0;
      active    <= '0;
      wholds    <= 1'b0;
      rhead     <= '0;
      rcnt      <= '0;
      whead     <= '0;
      wcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      pop_rd <= pop_rd_next;
      nres   <= nres_next;
      active <= active_next;
      wholds <= wholds_next;
      rhead  <= rhead_next;
      rcnt   <= rcnt_next;
      whead  <= whead_next;
      wcnt   <= wcnt_next;
      if (em) begin
        out_valid <= 1'b1;
      end else if (grant.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (em) begin
      out_id   <= em_id;
      out_wr   <= em_wr;
      out_st   <= em_st;
      out_last <= em_last;
    end
  end

  assign grant.valid          = out_valid;
  assign grant.grant_id       = out_id;
  assign grant.grant_is_write = out_wr;
  assign grant.status         = out_st;
  assign grant.last           = out_last;

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(wholds && active != '0))
    else $error("writer holds the lock while readers are active");

  a_rcnt_bound: assert property (@(posedge clk) disable iff (rst)
    rcnt <= CNT_W'(WAIT_DEPTH) && wcnt <= CNT_W'(WAIT_DEPTH))
    else $error("wait queue count beyond depth");

  a_reader_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP && pop_rd) |-> (rcnt != '0 && !wholds))
    else $error("reader wakeup with empty queue or writer holding");

  a_writer_pop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP && !pop_rd) |-> (wcnt != '0 && !wholds && active == '0))
    else $error("writer handoff while lock not free");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !grant.ready) |=> (out_valid && $stable(out_id)))
    else $error("pending result overwritten");

endmodule

/* design/fair_reader_writer_lock.sv */
// top level of the fair reader-writer lock manager
`timescale 1ns / 1ps

// Lock manager for many readers or one writer. Each request is a read or write
// acquire or release from a requester id; a request that must wait is held in a
// per-kind fifo wait queue of WAIT_DEPTH entries and produces its grant later,
// as a result of the release that frees the lock. Requests enter a two-entry
// queue and are taken by the lock engine one at a time. A request that is
// granted, queued or rejected at once is handled in the idle state; a release
// handing the lock to a waiting writer goes on to the pop state; a writer
// release that wakes readers stays there, reading one reader id per cycle from
// the wait queue ram unless the output stalls. At most 16 readers are woken per
// release. A result not yet taken at the output stalls the engine; the intake
// keeps taking requests until its two-entry queue is full, then stalls as well.
// Ids keep their low ID_BITS bits. No clearing pass is needed after reset.
module fair_reader_writer_lock import rwl_pkg::*; #(
  parameter int WAIT_DEPTH = 16,
  parameter int ID_BITS    = 8
) (
  input  logic        clk,
  input  logic        rst,
  rwl_req_if.sink     req,
  rwl_grant_if.source grant
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  rwl_front #(.ID_BITS(ID_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  rwl_back #(.WAIT_DEPTH(WAIT_DEPTH), .ID_BITS(ID_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .grant     (grant)
  );

endmodule
